// File: hw/rtl/sue_pkg.sv
// sue_pkg: shared types and constants of the string unescape / fnv-1a block
// character codes, fnv-1a constants, decode mode enum and decode result struct
// no dependencies
package sue_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_QUOTE  = 4'b0010,
    MODE_BTICK  = 4'b0100,
    MODE_BSLASH = 4'b1000
  } mode_t;

  // bytes produced by one input beat: n is 0, 1 or 2
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } dec_t;

endpackage

// File: hw/rtl/sue_in_if.sv
// sue_in_if: input channel carrying raw escaped bytes with a last flag
// depends on nothing
interface sue_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: hw/rtl/sue_out_if.sv
// sue_out_if: output channel carrying unescaped bytes with hash and length
// depends on sue_pkg for the count width
interface sue_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic [31:0]                     hash_so_far;
  logic [sue_pkg::COUNT_WIDTH-1:0] length_so_far;

  modport source (output valid, output out_byte, output out_last,
                  output hash_so_far, output length_so_far, input ready);
  modport sink   (input valid, input out_byte, input out_last,
                  input hash_so_far, input length_so_far, output ready);
endinterface

// File: hw/rtl/sue_decode.sv
// sue_decode: escape decoder, holds the pending mode and maps one raw byte
// to zero, one or two unescaped bytes; depends on sue_pkg
module sue_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output sue_pkg::dec_t dec
);

  sue_pkg::mode_t mode;
  sue_pkg::mode_t mode_next;
  logic           hold;
  sue_pkg::mode_t hold_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sue_pkg::MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  // byte that would itself become pending in normal mode
  always_comb begin
    hold = !in_last && (in_byte == sue_pkg::CH_QUOTE || in_byte == sue_pkg::CH_BTICK ||
                        in_byte == sue_pkg::CH_BSLASH);
    if (in_byte == sue_pkg::CH_QUOTE) begin
      hold_mode = sue_pkg::MODE_QUOTE;
    end else if (in_byte == sue_pkg::CH_BTICK) begin
      hold_mode = sue_pkg::MODE_BTICK;
    end else begin
      hold_mode = sue_pkg::MODE_BSLASH;
    end
  end

  always_comb begin
    dec.n    = 2'd0;
    dec.b0   = in_byte;
    dec.b1   = in_byte;
    dec.last = in_last;
    mode_next = sue_pkg::MODE_NORMAL;
    case (mode)
      sue_pkg::MODE_QUOTE, sue_pkg::MODE_BTICK: begin
        dec.b0 = (mode == sue_pkg::MODE_QUOTE) ? sue_pkg::CH_QUOTE : sue_pkg::CH_BTICK;
        if (in_byte == dec.b0) begin
          dec.n = 2'd1;
        end else if (hold) begin
          dec.n     = 2'd1;
          mode_next = hold_mode;
        end else begin
          dec.n = 2'd2;
        end
      end
      sue_pkg::MODE_BSLASH: begin
        dec.n = 2'd1;
        case (in_byte)
          sue_pkg::CH_N:      dec.b0 = sue_pkg::CH_LF;
          sue_pkg::CH_T:      dec.b0 = sue_pkg::CH_TAB;
          sue_pkg::CH_R:      dec.b0 = sue_pkg::CH_CR;
          sue_pkg::CH_BSLASH: dec.b0 = sue_pkg::CH_BSLASH;
          sue_pkg::CH_QUOTE:  dec.b0 = sue_pkg::CH_QUOTE;
          sue_pkg::CH_ZERO:   dec.b0 = sue_pkg::CH_NUL;
          default: begin
            dec.n  = 2'd2;
            dec.b0 = sue_pkg::CH_BSLASH;
          end
        endcase
      end
      default: begin
        if (hold) begin
          mode_next = hold_mode;
        end else begin
          dec.n = 2'd1;
        end
      end
    endcase
  end

endmodule

// File: hw/rtl/string_unescape_with_fnv1a_hash.sv
// string_unescape_with_fnv1a_hash: escape decoder with running fnv-1a hash
// an accepted beat passes through the byte queue and then the output register
// throughput: one input beat per cycle unless the output stalls or a beat yields two bytes,
// set by the byte queue and the one-byte-per-cycle hash multiply loop
// reset: synchronous, clears mode, queue, output valid, hash to basis, count
// depends on sue_pkg, sue_in_if, sue_out_if, sue_decode
module string_unescape_with_fnv1a_hash (
  input logic      clk,
  input logic      rst,
  sue_in_if.sink   esc,
  sue_out_if.source plain
);

  sue_pkg::dec_t dec;
  logic          accept;
  logic          out_load;
  logic          emit;

  logic [1:0] q_cnt;
  logic [7:0] q_b0;
  logic [7:0] q_b1;
  logic       q_last;
  logic       cur_last;

  logic [31:0]                     hash;
  logic [31:0]                     hash_next;
  logic [sue_pkg::COUNT_WIDTH-1:0] cnt;
  logic [sue_pkg::COUNT_WIDTH-1:0] cnt_next;

  logic                            o_valid;
  logic [7:0]                      o_byte;
  logic                            o_last;
  logic [31:0]                     o_hash;
  logic [sue_pkg::COUNT_WIDTH-1:0] o_len;

  sue_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (esc.in_byte),
    .in_last (esc.in_last),
    .dec     (dec)
  );

  assign out_load  = !o_valid || plain.ready;
  assign emit      = (q_cnt != 2'd0) && out_load;
  assign esc.ready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && out_load);
  assign accept    = esc.valid && esc.ready;
  assign cur_last  = (q_cnt == 2'd1) && q_last;

  assign hash_next = (hash ^ {24'd0, q_b0}) * sue_pkg::FNV_PRIME;
  assign cnt_next  = (cnt == sue_pkg::COUNT_MAX) ? cnt : cnt + 1'b1;

  // byte queue between decode and hash
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else if (accept) begin
      q_cnt <= dec.n;
    end else if (emit) begin
      q_cnt <= q_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_b0   <= dec.b0;
      q_b1   <= dec.b1;
      q_last <= dec.last;
    end else if (emit) begin
      q_b0 <= q_b1;
    end
  end

  // running hash and count
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= sue_pkg::FNV_BASIS;
      cnt  <= '0;
    end else if (emit) begin
      if (cur_last) begin
        hash <= sue_pkg::FNV_BASIS;
        cnt  <= '0;
      end else begin
        hash <= hash_next;
        cnt  <= cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= (q_cnt != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= q_b0;
      o_last <= cur_last;
      o_hash <= hash_next;
      o_len  <= cnt_next;
    end
  end

  assign plain.valid         = o_valid;
  assign plain.out_byte      = o_byte;
  assign plain.out_last      = o_last;
  assign plain.hash_so_far   = o_hash;
  assign plain.length_so_far = o_len;

endmodule

// File: tb/sv/unescape_checker.sv
// unescape_checker: predicts and checks the output beats of the escape decoder
// keeps its own copy of the pending mode, running fnv-1a hash and byte count
// depends on sue_pkg
module unescape_checker
  import sue_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             out_byte,
  input  logic                   out_last,
  input  logic [31:0]            out_hash,
  input  logic [COUNT_WIDTH-1:0] out_len,
  output int                     fails,
  output int                     due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]             b;
    logic                   last;
    logic [31:0]            hash;
    logic [COUNT_WIDTH-1:0] len;
  } plain_beat_t;

  plain_beat_t            plain_due[$];
  mode_t                  mode;
  logic [31:0]            hash_acc;
  logic [COUNT_WIDTH-1:0] count;

  function automatic void restart();
    mode     = MODE_NORMAL;
    hash_acc = FNV_BASIS;
    count    = '0;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic last);
    plain_beat_t beat;
    hash_acc = (hash_acc ^ {24'd0, b}) * FNV_PRIME;
    if (count != COUNT_MAX) begin
      count = count + 1'b1;
    end
    beat.b    = b;
    beat.last = last;
    beat.hash = hash_acc;
    beat.len  = count;
    plain_due.push_back(beat);
  endfunction

  function automatic void take_plain(input logic [7:0] b, input logic last);
    if (!last && b == CH_QUOTE) begin
      mode = MODE_QUOTE;
    end else if (!last && b == CH_BTICK) begin
      mode = MODE_BTICK;
    end else if (!last && b == CH_BSLASH) begin
      mode = MODE_BSLASH;
    end else begin
      mode = MODE_NORMAL;
      emit(b, last);
    end
  endfunction

  function automatic void unescape_step(input logic [7:0] b, input logic last);
    case (mode)
      MODE_QUOTE, MODE_BTICK: begin
        logic [7:0] held;
        held = (mode == MODE_QUOTE) ? CH_QUOTE : CH_BTICK;
        mode = MODE_NORMAL;
        if (b == held) begin
          emit(held, last);
        end else begin
          emit(held, 1'b0);
          take_plain(b, last);
        end
      end
      MODE_BSLASH: begin
        mode = MODE_NORMAL;
        case (b)
          CH_N:      emit(CH_LF, last);
          CH_T:      emit(CH_TAB, last);
          CH_R:      emit(CH_CR, last);
          CH_BSLASH: emit(CH_BSLASH, last);
          CH_QUOTE:  emit(CH_QUOTE, last);
          CH_ZERO:   emit(CH_NUL, last);
          default: begin
            emit(CH_BSLASH, 1'b0);
            emit(b, last);
          end
        endcase
      end
      default: take_plain(b, last);
    endcase
    if (last) begin
      restart();
    end
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: mismatch on %s: expected %h got %h", $realtime, field, want, got);
    fails++;
  endtask

  always @(posedge clk) begin
    plain_beat_t want;
    if (rst) begin
      restart();
      plain_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        unescape_step(in_byte, in_last);
      end
      if (out_valid && out_ready) begin
        if (plain_due.size() == 0) begin
          report("beat with none due", '0, {24'd0, out_byte});
        end else begin
          want = plain_due.pop_front();
          if (out_byte !== want.b) report("out_byte", {24'd0, want.b}, {24'd0, out_byte});
          if (out_last !== want.last) report("out_last", {31'd0, want.last}, {31'd0, out_last});
          if (out_hash !== want.hash) report("hash_so_far", want.hash, out_hash);
          if (out_len !== want.len) report("length_so_far", want.len, out_len);
        end
      end
    end
    due <= plain_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// tb: top of the escape decoder testbench, drives raw literals and random stalls
// directed literals, then random ones in four idle/stall phases
// depends on sue_pkg, sue_in_if, sue_out_if, string_unescape_with_fnv1a_hash, unescape_checker
module tb;
  import sue_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   due;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   sent      = 0;

  sue_in_if  esc ();
  sue_out_if plain ();

  string_unescape_with_fnv1a_hash dut (
    .clk   (clk),
    .rst   (rst),
    .esc   (esc),
    .plain (plain)
  );

  unescape_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (esc.valid),
    .in_ready  (esc.ready),
    .in_byte   (esc.in_byte),
    .in_last   (esc.in_last),
    .out_valid (plain.valid),
    .out_ready (plain.ready),
    .out_byte  (plain.out_byte),
    .out_last  (plain.out_last),
    .out_hash  (plain.hash_so_far),
    .out_len   (plain.length_so_far),
    .fails     (fails),
    .due       (due)
  );

  always #6 clk = ~clk;

  initial begin
    plain.ready <= 1'b0;
    forever begin
      @(posedge clk);
      plain.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      esc.valid <= 1'b0;
      @(posedge clk);
    end
    esc.valid   <= 1'b1;
    esc.in_byte <= b;
    esc.in_last <= last;
    do @(posedge clk); while (!esc.ready);
    sent++;
  endtask

  task automatic send_literal(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_beat(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic drain();
    esc.valid <= 1'b0;
    do @(posedge clk); while (due != 0);
  endtask

  // biased toward quotes, backticks, backslashes and the n, t, r and 0 escape characters
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(2))
        0: return CH_QUOTE;
        1: return CH_BTICK;
        default: return CH_BSLASH;
      endcase
    end else if (r < 60) begin
      case ($urandom_range(3))
        0: return CH_N;
        1: return CH_T;
        2: return CH_R;
        default: return CH_ZERO;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_literal(input int len);
    for (int i = 0; i < len; i++) begin
      send_beat(pick_byte(), i == len - 1);
    end
  endtask

  initial begin
    int phase_start;
    bit drained;
    drained     = 1'b0;
    esc.valid   <= 1'b0;
    esc.in_byte <= 8'h00;
    esc.in_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_literal('{8'h00, 8'hFF});
    send_literal('{CH_QUOTE, CH_QUOTE, CH_BTICK, CH_BTICK, CH_QUOTE, 8'h41,
                   CH_BTICK, CH_BSLASH, CH_N});
    send_literal('{CH_BSLASH, CH_T, CH_BSLASH, CH_R, CH_BSLASH, CH_BSLASH,
                   CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_ZERO, CH_BSLASH, 8'h78});
    send_literal('{CH_QUOTE});
    send_literal('{CH_BSLASH});
    send_literal('{CH_BTICK});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      phase_start = sent;
      while (sent - phase_start < 310) begin
        if ($urandom_range(9) == 0) begin
          send_random_literal($urandom_range(9, 40));
        end else begin
          send_random_literal($urandom_range(1, 8));
        end
        if (phase == 1 && !drained && sent - phase_start >= 150) begin
          drain();
          drained = 1'b1;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
